>>> sv/gwm_pkg.sv
`default_nettype none

package gwm_pkg;

  // default pattern capacity
  localparam int unsigned MAX_PATTERN_DEF = 32;

  // special characters, and the constants used for folding
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_VALUE  = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  // per-cycle control shared by every cell
  typedef struct packed {
    logic restart;
    logic advance;
    logic clear;
  } cell_ctl_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic carry;  // activity closed over a star at the left neighbour
    logic step;   // left neighbour consumed the value byte
  } link_t;

  // one result item
  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

  // fold upper case to lower case and backslash to slash
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CH_BSLASH) begin
      r = CH_SLASH;
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/gwm_cell.sv
`default_nettype none

module gwm_cell
  import gwm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctl_t  ctl_i,
  input  wire logic       wr_en_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       act_rst_i,
  input  wire link_t      lnk_i,
  output link_t           lnk_o,
  output logic            act_o
);

  logic [7:0] pat_r, pat_nxt;
  logic       vld_r, vld_nxt;
  logic       act_r, act_nxt;
  logic       star_nxt;
  logic       seed;
  logic       closed;

  // pattern byte held by this position
  always_comb begin
    vld_nxt = vld_r;
    if (ctl_i.clear) begin
      vld_nxt = 1'b0;
    end else if (wr_en_i) begin
      vld_nxt = 1'b1;
    end
  end

  assign pat_nxt  = wr_en_i ? byte_i : pat_r;
  assign star_nxt = vld_nxt && (pat_nxt == CH_STAR);

  // own activity: a star keeps itself active, a restart starts from the carry only
  assign seed   = ctl_i.advance && (lnk_i.step || (act_r && vld_r && pat_r == CH_STAR));
  assign closed = seed || lnk_i.carry;

  assign lnk_o.carry = closed && star_nxt;
  assign lnk_o.step  = act_r && vld_r && (pat_r == CH_QMARK || pat_r == byte_i);

  assign act_nxt = (ctl_i.restart || ctl_i.advance) ? closed : act_r;
  assign act_o   = act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      act_r <= act_rst_i;
    end else begin
      vld_r <= vld_nxt;
      act_r <= act_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

endmodule

`default_nettype wire

>>> sv/gwm_out_skid.sv
`default_nettype none

module gwm_out_skid
  import gwm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic out_free;

  assign out_free = !out_vld_r || out_ready_i;

  // output slot refills from the skid slot first, then from the new item
  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (out_free) begin
      if (skid_vld_r) begin
        out_vld_nxt   = 1'b1;
        out_data_nxt  = skid_data_r;
        skid_vld_nxt  = push_i;
        skid_data_nxt = push_data_i;
      end else begin
        out_vld_nxt  = push_i;
        out_data_nxt = push_data_i;
      end
    end else if (push_i) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign ready_o     = !skid_vld_r;
  assign out_valid_o = out_vld_r;
  assign out_data_o  = out_data_r;

endmodule

`default_nettype wire

>>> sv/glob_wildcard_matcher.sv
`default_nettype none

// channel  | ports                                          | direction
// ---------+------------------------------------------------+----------
// input    | in_valid, in_ready, in_operation, in_byte_in   | in
// result   | out_valid, out_ready, out_matched,             | out
//          | out_pattern_overflow                           |
//
// one item is taken every cycle while in_ready is high: each byte updates all
// pattern positions at once, with star activity rippling along the row
// of cells inside the cycle; a finish item's result is registered
// reset leaves an empty pattern with position zero active, no results held
// the result side holds up to two results; in_ready falls only when both wait

module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched,
  output logic            out_pattern_overflow
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  logic [LW-1:0]        len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 tail_r, tail_nxt;
  logic                 fire;
  op_t                  op;
  logic [7:0]           fbyte;
  logic                 full;
  cell_ctl_t            ctl;
  link_t                lnk [0:MAX_PATTERN];
  logic [MAX_PATTERN:0] act_vec;
  logic [MAX_PATTERN-1:0] wr_en;
  res_t                 res;
  res_t                 out_res;

  assign fire  = in_valid && in_ready;
  assign op    = op_t'(in_operation);
  assign fbyte = fold_byte(in_byte_in);
  assign full  = (len_r == LW'(MAX_PATTERN));

  // control for the row of cells
  always_comb begin
    ctl = '0;
    if (fire) begin
      case (op)
        OP_CLEAR: begin
          ctl.restart = 1'b1;
          ctl.clear   = 1'b1;
        end
        OP_APPEND: ctl.restart = 1'b1;
        OP_VALUE:  ctl.advance = 1'b1;
        OP_FINISH: ctl.restart = 1'b1;
        default:   ctl = '0;
      endcase
    end
  end

  // write strobe for the cell at the current length
  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      wr_en[p] = fire && (op == OP_APPEND) && (len_r == LW'(p));
    end
  end

  // length and overflow flag
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (fire) begin
      case (op)
        OP_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end
        OP_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LW'(1);
          end
        end
        default: begin
          len_nxt = len_r;
          ovf_nxt = ovf_r;
        end
      endcase
    end
  end

  // row of position cells; position zero is seeded on a restart
  assign lnk[0].carry = ctl.restart;
  assign lnk[0].step  = 1'b0;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    gwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .wr_en_i   (wr_en[g]),
      .byte_i    (fbyte),
      .act_rst_i ((g == 0) ? 1'b1 : 1'b0),
      .lnk_i     (lnk[g]),
      .lnk_o     (lnk[g+1]),
      .act_o     (act_vec[g])
    );
  end

  // position past the last cell
  assign tail_nxt = (ctl.restart || ctl.advance)
                  ? ((ctl.advance && lnk[MAX_PATTERN].step) || lnk[MAX_PATTERN].carry)
                  : tail_r;
  assign act_vec[MAX_PATTERN] = tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      tail_r <= tail_nxt;
    end
  end

  // result of a finish item
  assign res.matched  = act_vec[len_r];
  assign res.overflow = ovf_r;

  gwm_out_skid u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (fire && op == OP_FINISH),
    .push_data_i (res),
    .ready_o     (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_res)
  );

  assign out_matched          = out_res.matched;
  assign out_pattern_overflow = out_res.overflow;

  // length never passes capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  // a clear empties the pattern and drops the overflow flag
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op == OP_CLEAR) |=> (len_r == '0 && !ovf_r))
    else $error("clear did not empty the pattern");

  // every restart leaves position zero active
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.restart |=> act_vec[0])
    else $error("position zero inactive after restart");

  // overflow only from an append to a full pattern
  a_ovf_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(fire && op == OP_APPEND && full))
    else $error("overflow flag set without a dropped byte");

endmodule

`default_nettype wire
